### sv/plpp_pkg.sv
package plpp_pkg;

  localparam logic [7:0] SEG_CLASS_8      = 8'h20;
  localparam logic [7:0] SEG_CLASS_16     = 8'h21;
  localparam logic [7:0] SEG_INSTANCE_8   = 8'h24;
  localparam logic [7:0] SEG_INSTANCE_16  = 8'h25;
  localparam logic [7:0] SEG_ATTRIBUTE_8  = 8'h30;
  localparam logic [7:0] SEG_ATTRIBUTE_16 = 8'h31;

  localparam int unsigned WordsWidth = 9;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TYPE,
    PH_VAL8,
    PH_PAD,
    PH_LO,
    PH_HI,
    PH_ERR
  } phase_e;

  typedef enum logic [1:0] {
    TGT_CLASS,
    TGT_INSTANCE,
    TGT_ATTRIBUTE
  } target_e;

  typedef struct packed {
    logic        status;
    logic [15:0] class_value;
    logic [15:0] instance_value;
    logic [15:0] attribute_value;
    logic [7:0]  path_words;
    logic [9:0]  bytes_consumed;
  } result_t;

endpackage

### sv/plpp_if.sv
interface plpp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       path_start;

  modport source(output valid, output data_byte, output path_start, input ready);
  modport sink(input valid, input data_byte, input path_start, output ready);
endinterface

interface plpp_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [15:0] class_value;
  logic [15:0] instance_value;
  logic [15:0] attribute_value;
  logic [7:0]  path_words;
  logic [9:0]  bytes_consumed;

  modport source(
    output valid, output status, output class_value, output instance_value,
    output attribute_value, output path_words, output bytes_consumed, input ready
  );
  modport sink(
    input valid, input status, input class_value, input instance_value,
    input attribute_value, input path_words, input bytes_consumed, output ready
  );
endinterface

### sv/padded_logical_path_parser_core.sv
// Byte-serial parser for padded logical paths. Each transfer on in_i carries one byte;
// path_start marks the size byte and restarts the parser at any point. A byte passes
// through an input register and is parsed from there, so one byte is taken every clock
// while out_o is ready, and a closing byte's result goes on through the result register.
// A path ends with one result transfer on out_o holding the class, instance and attribute
// ids, or with status set and zero ids on a reserved or unknown segment type, after which
// bytes are ignored until the next path_start. The result register holds a waiting
// result while other bytes are still parsed; a closing byte waits in the input register.
module padded_logical_path_parser_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  plpp_in_if.sink   in_i,
  plpp_out_if.source out_o
);
  import plpp_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_start_q;
  logic       out_valid_q;
  result_t    out_res_q;
  logic       res_valid;
  result_t    res;
  logic       out_free;
  logic       step;

  assign out_free   = !out_valid_q || out_o.ready;
  assign step       = in_valid_q && (!res_valid || out_free);
  assign in_i.ready = !in_valid_q || step;

  plpp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .data_byte_i (in_byte_q),
    .path_start_i(in_start_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q  <= in_i.data_byte;
      in_start_q <= in_i.path_start;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.status          = out_res_q.status;
  assign out_o.class_value     = out_res_q.class_value;
  assign out_o.instance_value  = out_res_q.instance_value;
  assign out_o.attribute_value = out_res_q.attribute_value;
  assign out_o.path_words      = out_res_q.path_words;
  assign out_o.bytes_consumed  = out_res_q.bytes_consumed;

endmodule

### sv/plpp_parser.sv
module plpp_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       data_byte_i,
  input  logic             path_start_i,
  output logic             res_valid_o,
  output plpp_pkg::result_t res_o
);
  import plpp_pkg::*;

  phase_e                phase_q, phase_d;
  target_e               target_q, target_d;
  logic [7:0]            size_q, size_d;
  logic [WordsWidth-1:0] words_q, words_d;
  logic [7:0]            low_q, low_d;
  logic [15:0]           class_q, class_d;
  logic [15:0]           inst_q, inst_d;
  logic [15:0]           attr_q, attr_d;
  logic                  emit;
  logic                  err;
  logic                  store;
  logic [15:0]           store_val;

  always_comb begin
    phase_d   = phase_q;
    target_d  = target_q;
    size_d    = size_q;
    words_d   = words_q;
    low_d     = low_q;
    emit      = 1'b0;
    err       = 1'b0;
    store     = 1'b0;
    store_val = {8'h00, data_byte_i};

    if (path_start_i) begin
      size_d   = data_byte_i;
      words_d  = '0;
      target_d = TGT_CLASS;
      low_d    = '0;
      if (data_byte_i == 8'h00) begin
        emit = 1'b1;
      end else begin
        phase_d = PH_TYPE;
      end
    end else begin
      unique case (phase_q)
        PH_TYPE: begin
          case (data_byte_i)
            SEG_CLASS_8: begin
              target_d = TGT_CLASS;
              phase_d  = PH_VAL8;
            end
            SEG_INSTANCE_8: begin
              target_d = TGT_INSTANCE;
              phase_d  = PH_VAL8;
            end
            SEG_ATTRIBUTE_8: begin
              target_d = TGT_ATTRIBUTE;
              phase_d  = PH_VAL8;
            end
            SEG_CLASS_16: begin
              target_d = TGT_CLASS;
              phase_d  = PH_PAD;
            end
            SEG_INSTANCE_16: begin
              target_d = TGT_INSTANCE;
              phase_d  = PH_PAD;
            end
            SEG_ATTRIBUTE_16: begin
              target_d = TGT_ATTRIBUTE;
              phase_d  = PH_PAD;
            end
            default: begin
              emit = 1'b1;
              err  = 1'b1;
            end
          endcase
        end
        PH_VAL8: begin
          store   = 1'b1;
          words_d = words_q + WordsWidth'(1);
          if (words_d >= {1'b0, size_q}) begin
            emit = 1'b1;
          end else begin
            phase_d = PH_TYPE;
          end
        end
        PH_PAD: begin
          phase_d = PH_LO;
        end
        PH_LO: begin
          low_d   = data_byte_i;
          phase_d = PH_HI;
        end
        PH_HI: begin
          store     = 1'b1;
          store_val = {data_byte_i, low_q};
          words_d   = words_q + WordsWidth'(2);
          if (words_d >= {1'b0, size_q}) begin
            emit = 1'b1;
          end else begin
            phase_d = PH_TYPE;
          end
        end
        default: begin
        end
      endcase
    end

    if (path_start_i) begin
      class_d = '0;
      inst_d  = '0;
      attr_d  = '0;
    end else begin
      class_d = (store && target_q == TGT_CLASS) ? store_val : class_q;
      inst_d  = (store && target_q == TGT_INSTANCE) ? store_val : inst_q;
      attr_d  = (store && target_q != TGT_CLASS && target_q != TGT_INSTANCE) ?
                store_val : attr_q;
    end

    if (emit) begin
      phase_d = err ? PH_ERR : PH_IDLE;
    end

    res_valid_o           = emit;
    res_o.status          = err;
    res_o.class_value     = err ? 16'h0000 : class_d;
    res_o.instance_value  = err ? 16'h0000 : inst_d;
    res_o.attribute_value = err ? 16'h0000 : attr_d;
    res_o.path_words      = size_d;
    res_o.bytes_consumed  = err ? 10'h000 : {words_d, 1'b1};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      target_q <= TGT_CLASS;
      size_q   <= '0;
      words_q  <= '0;
      low_q    <= '0;
      class_q  <= '0;
      inst_q   <= '0;
      attr_q   <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      target_q <= target_d;
      size_q   <= size_d;
      words_q  <= words_d;
      low_q    <= low_d;
      class_q  <= class_d;
      inst_q   <= inst_d;
      attr_q   <= attr_d;
    end
  end

endmodule

### sv/plpp_checker.sv
module plpp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        status_i,
  input logic [15:0] class_value_i,
  input logic [15:0] instance_value_i,
  input logic [15:0] attribute_value_i,
  input logic [7:0]  path_words_i,
  input logic [9:0]  bytes_consumed_i
);

  // A stalled result stays valid and keeps its status, class id and byte count until the transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(bytes_consumed_i) &&
    $stable(status_i) && $stable(class_value_i))
    else $error("result changed while stalled");

  // An error result carries no ids and no byte count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i |-> class_value_i == 16'h0000 &&
    instance_value_i == 16'h0000 && attribute_value_i == 16'h0000 &&
    bytes_consumed_i == 10'h000)
    else $error("error result with nonzero fields");

  // A decoded path counts the size byte, so the count is odd.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !status_i |-> bytes_consumed_i[0])
    else $error("decoded byte count is even");

  // A decoded path covers at least the words that its size byte gives.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !status_i |-> bytes_consumed_i[9:1] >= {1'b0, path_words_i})
    else $error("decoded path shorter than its size");

endmodule

bind padded_logical_path_parser_core plpp_checker u_plpp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .status_i         (out_o.status),
  .class_value_i    (out_o.class_value),
  .instance_value_i (out_o.instance_value),
  .attribute_value_i(out_o.attribute_value),
  .path_words_i     (out_o.path_words),
  .bytes_consumed_i (out_o.bytes_consumed)
);

### test/padded_logical_path_parser_core_tb.sv
module padded_logical_path_parser_core_tb;
  import plpp_pkg::*;

  localparam int unsigned IdleLimit = 1000;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned RandomBytes = 1800;

  class path_checker;
    phase_e      phase;
    logic [7:0]  size_words;
    logic [8:0]  words_done;
    target_e     target;
    logic [7:0]  low_hold;
    logic [15:0] class_hold;
    logic [15:0] instance_id;
    logic [15:0] attribute_id;
    result_t     pending_paths[$];
    int          errors;
    int          decoded_paths;
    int          failed_paths;

    function new();
      phase = PH_IDLE;
      size_words = '0;
      words_done = '0;
      target = TGT_CLASS;
      low_hold = '0;
      class_hold = '0;
      instance_id = '0;
      attribute_id = '0;
      errors = 0;
      decoded_paths = 0;
      failed_paths = 0;
    endfunction

    function void store_id(logic [15:0] v);
      case (target)
        TGT_CLASS:    class_hold = v;
        TGT_INSTANCE: instance_id = v;
        default:      attribute_id = v;
      endcase
    endfunction

    function void close_path(bit bad);
      result_t r;
      r.status          = bad;
      r.class_value     = bad ? 16'h0 : class_hold;
      r.instance_value  = bad ? 16'h0 : instance_id;
      r.attribute_value = bad ? 16'h0 : attribute_id;
      r.path_words      = size_words;
      r.bytes_consumed  = bad ? 10'h0 : 10'(words_done * 2 + 1);
      pending_paths.push_back(r);
      phase = bad ? PH_ERR : PH_IDLE;
      if (bad) begin
        failed_paths++;
      end else begin
        decoded_paths++;
      end
    endfunction

    function void count_words();
      if (words_done >= {1'b0, size_words}) begin
        close_path(1'b0);
      end else begin
        phase = PH_TYPE;
      end
    endfunction

    // Returns 0 when the byte is ignored by the parser.
    function bit take_byte(logic [7:0] b, logic start);
      bit used = 1'b1;
      if (start) begin
        size_words = b;
        words_done = '0;
        target = TGT_CLASS;
        low_hold = '0;
        class_hold = '0;
        instance_id = '0;
        attribute_id = '0;
        count_words();
        return 1'b1;
      end
      case (phase)
        PH_TYPE: begin
          if (b[7:5] == 3'b111) begin
            close_path(1'b1);
          end else begin
            case (b)
              SEG_CLASS_8: begin
                target = TGT_CLASS;
                phase = PH_VAL8;
              end
              SEG_INSTANCE_8: begin
                target = TGT_INSTANCE;
                phase = PH_VAL8;
              end
              SEG_ATTRIBUTE_8: begin
                target = TGT_ATTRIBUTE;
                phase = PH_VAL8;
              end
              SEG_CLASS_16: begin
                target = TGT_CLASS;
                phase = PH_PAD;
              end
              SEG_INSTANCE_16: begin
                target = TGT_INSTANCE;
                phase = PH_PAD;
              end
              SEG_ATTRIBUTE_16: begin
                target = TGT_ATTRIBUTE;
                phase = PH_PAD;
              end
              default: close_path(1'b1);
            endcase
          end
        end
        PH_VAL8: begin
          store_id({8'h00, b});
          words_done = words_done + 9'd1;
          count_words();
        end
        PH_PAD: phase = PH_LO;
        PH_LO: begin
          low_hold = b;
          phase = PH_HI;
        end
        PH_HI: begin
          store_id({b, low_hold});
          words_done = words_done + 9'd2;
          count_words();
        end
        default: used = 1'b0;
      endcase
      return used;
    endfunction

    function void compare(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_paths.size() == 0) begin
        $error("result with no path pending: status %0d, bytes_consumed %0d",
               got.status, got.bytes_consumed);
        errors++;
        return;
      end
      want = pending_paths.pop_front();
      compare("status", want.status, got.status);
      compare("class_value", want.class_value, got.class_value);
      compare("instance_value", want.instance_value, got.instance_value);
      compare("attribute_value", want.attribute_value, got.attribute_value);
      compare("path_words", want.path_words, got.path_words);
      compare("bytes_consumed", want.bytes_consumed, got.bytes_consumed);
    endfunction

    function int pending();
      return pending_paths.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   running;

  plpp_in_if  in_bus ();
  plpp_out_if out_bus ();

  padded_logical_path_parser_core dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  path_checker board;
  result_t     seen;
  int          parsed_bytes;
  int          burst_left;
  int          idle_cycles;
  int          rx_mode;
  int          rx_left;
  int          hold_left;
  int          holds_done;
  bit          hold_req;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  task automatic send_byte(input logic [7:0] b, input logic start);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_bus.valid      <= 1'b1;
    in_bus.data_byte  <= b;
    in_bus.path_start <= start;
    do begin
      @(posedge clk);
    end while (!in_bus.ready);
    if (board.take_byte(b, start)) begin
      parsed_bytes++;
    end
    burst_left--;
  endtask

  function automatic logic [7:0] id_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] bad_type();
    logic [7:0] t;
    if ($urandom_range(1) == 0) begin
      return {3'b111, 5'($urandom_range(31))};
    end
    do begin
      t = 8'($urandom_range(255));
    end while (t == SEG_CLASS_8 || t == SEG_INSTANCE_8 || t == SEG_ATTRIBUTE_8 ||
               t == SEG_CLASS_16 || t == SEG_INSTANCE_16 || t == SEG_ATTRIBUTE_16);
    return t;
  endfunction

  task automatic send_path(input logic [7:0] size, input bit wide_only);
    int         words;
    int         n;
    int         cut;
    logic [7:0] seg[4];
    send_byte(size, 1'b1);
    words = 0;
    while (words < size) begin
      if (!wide_only && $urandom_range(99) < 4) begin
        send_byte(bad_type(), 1'b0);
        repeat ($urandom_range(3)) send_byte(8'($urandom_range(255)), 1'b0);
        return;
      end
      case (wide_only ? $urandom_range(3, 5) : $urandom_range(5))
        0:       seg[0] = SEG_CLASS_8;
        1:       seg[0] = SEG_INSTANCE_8;
        2:       seg[0] = SEG_ATTRIBUTE_8;
        3:       seg[0] = SEG_CLASS_16;
        4:       seg[0] = SEG_INSTANCE_16;
        default: seg[0] = SEG_ATTRIBUTE_16;
      endcase
      if (seg[0][0]) begin
        seg[1] = 8'($urandom_range(255));
        seg[2] = id_byte();
        seg[3] = id_byte();
        n = 4;
      end else begin
        seg[1] = id_byte();
        n = 2;
      end
      cut = (!wide_only && $urandom_range(99) < 3) ? $urandom_range(1, n - 1) : n;
      for (int i = 0; i < cut; i++) begin
        send_byte(seg[i], 1'b0);
      end
      if (cut < n) begin
        return;
      end
      words += seg[0][0] ? 2 : 1;
    end
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 10)) begin
      send_byte(8'($urandom_range(255)), $urandom_range(4) == 0);
    end
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HoldCycles - 1;
      holds_done++;
      out_bus.ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(3);
        rx_left = $urandom_range(20, 200);
      end
      rx_left--;
      case (rx_mode)
        0:       out_bus.ready <= 1'b1;
        1:       out_bus.ready <= 1'($urandom_range(1));
        2:       out_bus.ready <= ($urandom_range(7) != 0);
        default: out_bus.ready <= ((rx_left % 5) >= 2);
      endcase
    end
  end

  always @(posedge clk) begin
    if (running) begin
      if (out_bus.valid && out_bus.ready) begin
        seen.status          = out_bus.status;
        seen.class_value     = out_bus.class_value;
        seen.instance_value  = out_bus.instance_value;
        seen.attribute_value = out_bus.attribute_value;
        seen.path_words      = out_bus.path_words;
        seen.bytes_consumed  = out_bus.bytes_consumed;
        board.check_result(seen);
      end
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("Watchdog: no transfer for %0d cycles, %0d results outstanding.",
                 idle_cycles, board.pending());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    int roll;
    board = new();
    parsed_bytes = 0;
    burst_left = 0;
    idle_cycles = 0;
    rx_mode = 0;
    rx_left = 0;
    hold_left = 0;
    holds_done = 0;
    hold_req = 1'b0;
    running = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.data_byte = 8'h00;
    in_bus.path_start = 1'b0;
    out_bus.ready = 1'b0;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    running = 1'b1;

    // A stray byte while idle, then an empty path.
    send_byte(SEG_CLASS_8, 1'b0);
    send_byte(8'd0, 1'b1);
    // Zero class and a full-scale 16-bit instance.
    send_byte(8'd3, 1'b1);
    send_byte(SEG_CLASS_8, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(SEG_INSTANCE_16, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    // The last 16-bit segment passes the size by one word.
    send_byte(8'd2, 1'b1);
    send_byte(SEG_INSTANCE_8, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(SEG_CLASS_16, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h12, 1'b0);
    // A path dropped by a new size byte in the middle of it.
    send_byte(8'd5, 1'b1);
    send_byte(SEG_ATTRIBUTE_8, 1'b0);
    send_byte(8'h07, 1'b0);
    send_byte(8'd2, 1'b1);
    send_byte(SEG_ATTRIBUTE_16, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    // Reserved and unknown segment types, each followed by an ignored byte.
    send_byte(8'd255, 1'b1);
    send_byte(8'hE0, 1'b0);
    send_byte(SEG_INSTANCE_8, 1'b0);
    send_byte(8'd1, 1'b1);
    send_byte(8'h22, 1'b0);
    send_byte(8'hFF, 1'b0);

    // The result side holds off while the longest path begins to stream in.
    parsed_bytes = 0;
    hold_req = 1'b1;
    send_path(8'd255, 1'b1);
    while (parsed_bytes < RandomBytes) begin
      if (holds_done < 2 && parsed_bytes > RandomBytes / 2) begin
        hold_req = 1'b1;
      end
      roll = $urandom_range(99);
      if (roll < 85) begin
        roll = $urandom_range(99);
        if (roll < 10) begin
          send_path(8'd0, 1'b0);
        end else if (roll < 80) begin
          send_path(8'($urandom_range(1, 6)), 1'b0);
        end else if (roll < 97) begin
          send_path(8'($urandom_range(7, 24)), 1'b0);
        end else begin
          send_path(8'($urandom_range(25, 60)), 1'b0);
        end
      end else begin
        send_noise();
      end
    end
    in_bus.valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Covered %0d parsed bytes: %0d paths decoded, %0d ended on a bad segment type.",
             parsed_bytes, board.decoded_paths, board.failed_paths);
    $display("Result side held off %0d times for %0d cycles each.", holds_done, HoldCycles);
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
